>>> hdl/can_mfr_pkg.sv
`default_nettype none
package can_mfr_pkg;

  // register file layout
  localparam int unsigned NUM_MAP_REGS = 5;
  localparam int unsigned ADDR_W       = 5;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_MAPPING_0 = 3'd1;
  localparam logic [2:0] REG_MAPPING_1 = 3'd2;
  localparam logic [2:0] REG_MAPPING_2 = 3'd3;
  localparam logic [2:0] REG_MAPPING_3 = 3'd4;
  localparam logic [2:0] REG_MAPPING_4 = 3'd5;
  localparam logic [2:0] REG_BYP_MASK  = 3'd6;
  localparam logic [2:0] REG_BYP_TAG   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_FWD  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // bus widths
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef struct packed {
    logic                                 enable;
    logic [NUM_MAP_REGS-1:0][31:0]        mapping;
    logic [15:0]                          byp_mask;
    logic [15:0]                          byp_tag;
  } cfg_t;

  // what the captured frame asks for
  typedef enum logic [2:0] {
    EV_DROP      = 3'd0,
    EV_SEG_RESET = 3'd1,
    EV_FWD       = 3'd2,
    EV_ERR       = 3'd3,
    EV_STORE     = 3'd4
  } ev_t;

  typedef struct packed {
    logic capture;
    logic load_single;
    logic seg_reset;
    logic rd_seg;
    logic merge;
    logic word_clr;
    logic rd_word;
    logic load_word;
  } cmd_t;

  typedef struct packed {
    ev_t  ev;
    logic seg_done;
    logic last_word;
    logic out_free;
  } sts_t;

  // low n bytes set, n of eight or more gives all ones
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < n) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hdl/can_mfr_ctrl.sv
`default_nettype none
module can_mfr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire can_mfr_pkg::sts_t  sts,
  output can_mfr_pkg::cmd_t       cmd
);
  import can_mfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_MERGE = 5'b00100,
    S_RD    = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts.ev)
          EV_DROP: state_nxt = S_IDLE;
          EV_SEG_RESET: begin
            cmd.seg_reset = 1'b1;
            state_nxt     = S_IDLE;
          end
          EV_FWD, EV_ERR: begin
            if (sts.out_free) begin
              cmd.load_single = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          EV_STORE: begin
            cmd.rd_seg = 1'b1;
            state_nxt  = S_MERGE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (sts.seg_done) begin
          cmd.word_clr = 1'b1;
          state_nxt    = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_word = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_word = 1'b1;
          state_nxt     = sts.last_word ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/can_mfr_dp.sv
`default_nettype none
module can_mfr_dp #(
  parameter int unsigned MAPPINGS = 5,
  parameter int unsigned SEGMENTS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire can_mfr_pkg::cfg_t                      cfg,
  input  wire logic [can_mfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire can_mfr_pkg::cmd_t                      cmd,
  output can_mfr_pkg::sts_t                           sts,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [can_mfr_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [can_mfr_pkg::OUT_TUSER_W-1:0]         out_tuser,
  output logic                                        out_tlast
);
  import can_mfr_pkg::*;

  localparam int unsigned DEPTH = MAPPINGS * SEGMENTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW    = (MAPPINGS > 1) ? $clog2(MAPPINGS) : 1;
  localparam logic [6:0]  MAX_BYTES = 7'(SEGMENTS * 8);

  // captured frame
  logic [15:0] id_r;
  logic [63:0] data_r;
  logic [3:0]  len_r;
  logic [31:0] time_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= in_tdata[15:0];
      data_r <= in_tdata[79:16];
      len_r  <= (in_tdata[83:80] > 4'd8) ? 4'd8 : in_tdata[83:80];
      time_r <= in_tdata[115:84];
    end
  end

  logic [2:0] sid, seg;
  logic [4:0] board;
  assign sid   = id_r[10:8];
  assign seg   = id_r[7:5];
  assign board = id_r[4:0];

  // mapping match, lowest entry wins
  logic          found;
  logic [MW-1:0] m;
  logic [31:0]   e;

  always_comb begin
    found = 1'b0;
    m     = '0;
    e     = '0;
    for (int i = MAPPINGS - 1; i >= 0; i--) begin
      if (cfg.mapping[i][7:5] == sid && cfg.mapping[i][4:0] == board) begin
        found = 1'b1;
        m     = MW'(i);
        e     = cfg.mapping[i];
      end
    end
  end

  // message geometry
  logic [6:0] size;
  logic [7:0] size_up;
  logic [3:0] segs;
  assign size    = (e[14:8] > MAX_BYTES) ? MAX_BYTES : e[14:8];
  assign size_up = {1'b0, size} + 8'd7;
  assign segs    = size_up[6:3];

  // per-mapping segment counters
  logic [MAPPINGS-1:0][3:0] nseg_r;
  logic [3:0] nseg, nseg_inc;
  assign nseg     = nseg_r[m];
  assign nseg_inc = nseg + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nseg_r <= '0;
    end else if (cmd.seg_reset) begin
      nseg_r[m] <= '0;
    end else if (cmd.merge) begin
      nseg_r[m] <= (nseg_inc == segs) ? 4'd0 : nseg_inc;
    end
  end

  // frame decision
  logic [6:0] seg_end;
  ev_t        ev;
  assign seg_end = {1'b0, seg, 3'b000} + {3'b000, len_r};

  always_comb begin
    if (!cfg.enable || len_r == 4'd0)               ev = EV_DROP;
    else if (!found)                                ev = ((id_r & cfg.byp_mask) != 16'd0)
                                                         ? EV_ERR : EV_FWD;
    else if ({1'b0, seg} != nseg)                   ev = EV_SEG_RESET;
    else if ({1'b0, seg} >= segs || seg_end > size) ev = EV_ERR;
    else                                            ev = EV_STORE;
  end

  assign sts.ev = ev;

  // word counter for message output
  logic [2:0] wcnt_r;
  always_ff @(posedge clk) begin
    if (cmd.word_clr)       wcnt_r <= '0;
    else if (cmd.load_word) wcnt_r <= wcnt_r + 3'd1;
  end

  assign sts.seg_done  = (nseg_inc == segs);
  assign sts.last_word = (({1'b0, wcnt_r} + 4'd1) == segs);

  // reassembly store with per-entry valid bits
  logic [AW-1:0] addr_seg, addr_word, rd_addr;
  assign addr_seg  = AW'(int'(m) * SEGMENTS + int'(seg));
  assign addr_word = AW'(int'(m) * SEGMENTS + int'(wcnt_r));
  assign rd_addr   = cmd.rd_seg ? addr_seg : addr_word;

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [63:0]      rd_q_r;
  logic             rd_vld_r;
  logic [63:0]      old_word, merged, seg_mask;

  assign old_word = rd_vld_r ? rd_q_r : 64'd0;
  assign seg_mask = byte_mask(len_r);
  assign merged   = (old_word & ~seg_mask) | (data_r & seg_mask);

  always_ff @(posedge clk) begin
    if (cmd.merge) mem[addr_seg] <= merged;
    if (cmd.rd_seg || cmd.rd_word) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         vld_r <= '0;
    else if (cmd.merge) vld_r[addr_seg] <= 1'b1;
  end

  // bytes of this word inside the message
  logic [6:0] rem;
  logic [3:0] wbytes;
  assign rem    = size - {1'b0, wcnt_r, 3'b000};
  assign wbytes = (rem >= 7'd8) ? 4'd8 : rem[3:0];

  // output register
  logic        out_vld_r;
  logic [1:0]  o_kind_r;
  logic [15:0] o_id_r;
  logic [6:0]  o_len_r;
  logic [31:0] o_time_r;
  logic [2:0]  o_idx_r;
  logic [63:0] o_word_r;
  logic        o_last_r;

  assign sts.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n)                                out_vld_r <= 1'b0;
    else if (cmd.load_single || cmd.load_word) out_vld_r <= 1'b1;
    else if (out_tready)                       out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      o_time_r <= time_r;
      o_idx_r  <= '0;
      o_last_r <= 1'b1;
      if (ev == EV_FWD) begin
        o_kind_r <= KIND_FWD;
        o_id_r   <= id_r | cfg.byp_tag;
        o_len_r  <= {3'b000, len_r};
        o_word_r <= data_r & seg_mask;
      end else begin
        o_kind_r <= KIND_ERR;
        o_id_r   <= id_r;
        o_len_r  <= '0;
        o_word_r <= '0;
      end
    end else if (cmd.load_word) begin
      o_kind_r <= KIND_WORD;
      o_id_r   <= e[31:16];
      o_len_r  <= size;
      o_time_r <= time_r;
      o_idx_r  <= wcnt_r;
      o_word_r <= old_word & byte_mask(wbytes);
      o_last_r <= sts.last_word;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, o_word_r, o_idx_r, o_time_r, o_len_r, o_id_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

>>> hdl/can_multiframe_reassembler.sv
// CAN multi-frame reassembler. A frame's identifier carries a short id (10:8),
// a segment number (7:5) and a board (4:0); short id and board select one of
// the configured mappings, whose segments are gathered into a store of
// SEGMENTS words per mapping and sent out as a run of 64-bit words once the
// last segment is in. Frames that match no mapping are forwarded as one word
// or flagged as errors. One item at a time: each item is captured and then
// evaluated; a stored segment is also merged into the store, and a completing
// segment then reads the store and loads the output register for each message
// word. A busy output register stalls the item. The store reads as zero after
// reset through per-entry valid bits, so no clearing pass is needed. Configure
// only while idle; registers read back over the same port.
`default_nettype none
module can_multiframe_reassembler #(
  parameter int unsigned MAPPINGS = 5,
  parameter int unsigned SEGMENTS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // in_tdata: can_id[15:0], frame_data[79:16], frame_length[83:80],
  // frame_time[115:84], zero fill
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [can_mfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: message_id[15:0], message_length[22:16], message_time[54:23],
  // word_index[57:55], payload_word[121:58], zero fill
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [can_mfr_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tuser: kind[1:0]
  output logic [can_mfr_pkg::OUT_TUSER_W-1:0]         out_tuser,
  output logic                                        out_tlast,
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic [can_mfr_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire logic [31:0]                            cfg_pwdata,
  output logic [31:0]                                 cfg_prdata,
  output logic                                        cfg_pready
);
  import can_mfr_pkg::*;

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:    cfg_r.enable     <= cfg_pwdata[0];
        REG_MAPPING_0: cfg_r.mapping[0] <= cfg_pwdata;
        REG_MAPPING_1: cfg_r.mapping[1] <= cfg_pwdata;
        REG_MAPPING_2: cfg_r.mapping[2] <= cfg_pwdata;
        REG_MAPPING_3: cfg_r.mapping[3] <= cfg_pwdata;
        REG_MAPPING_4: cfg_r.mapping[4] <= cfg_pwdata;
        REG_BYP_MASK:  cfg_r.byp_mask   <= cfg_pwdata[15:0];
        REG_BYP_TAG:   cfg_r.byp_tag    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    cfg_prdata = {31'd0, cfg_r.enable};
      REG_MAPPING_0: cfg_prdata = cfg_r.mapping[0];
      REG_MAPPING_1: cfg_prdata = cfg_r.mapping[1];
      REG_MAPPING_2: cfg_prdata = cfg_r.mapping[2];
      REG_MAPPING_3: cfg_prdata = cfg_r.mapping[3];
      REG_MAPPING_4: cfg_prdata = cfg_r.mapping[4];
      REG_BYP_MASK:  cfg_prdata = {16'd0, cfg_r.byp_mask};
      REG_BYP_TAG:   cfg_prdata = {16'd0, cfg_r.byp_tag};
      default:       cfg_prdata = '0;
    endcase
  end

  can_mfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  can_mfr_dp #(
    .MAPPINGS (MAPPINGS),
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a merge always uses the store word read in the cycle before
  a_merge_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge |-> $past(cmd.rd_seg))
    else $error("merge without preceding store read");

  // results are loaded only when the output register can take them
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_single || cmd.load_word) |-> sts.out_free)
    else $error("output register overwritten");

  // one item at a time: an accepted item closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened while item in work");

endmodule
`default_nettype wire
